// File: rtl/core/fcirc_pkg.sv
// ----------------------------------------------------------------------------
// fcirc_pkg
// Shared types and constants of the circular-history FIR filter.
// ----------------------------------------------------------------------------
package fcirc_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W   = 16;
  localparam int COEF_IDX_W = 10;
  localparam int TAPCNT_W   = 11;
  localparam int PROD_W     = 2 * SAMPLE_W;

  // Q1.15 scaling, round half up, then clamp to the sample range
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  // Item commands
  typedef enum logic [1:0] {
    CMD_FILTER = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Sequencer to MAC unit
  typedef struct packed {
    logic start;   // clear the accumulator
    logic mul_en;  // operands valid this cycle
  } mac_ctrl_t;

  // MAC unit to sequencer
  typedef struct packed {
    logic busy;    // a product is still on its way to the accumulator
  } mac_stat_t;

endpackage

// File: rtl/core/fcirc_in_if.sv
// ----------------------------------------------------------------------------
// fcirc_in_if
// Input item channel: valid/ready handshake with command and operands.
// ----------------------------------------------------------------------------
interface fcirc_in_if
  import fcirc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [SAMPLE_W-1:0]  sample_in;
  logic [COEF_IDX_W-1:0]       coef_index;
  logic signed [SAMPLE_W-1:0]  coef_value;

  modport source (
    output valid, command, sample_in, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, command, sample_in, coef_index, coef_value,
    output ready
  );
endinterface

// File: rtl/core/fcirc_out_if.sv
// ----------------------------------------------------------------------------
// fcirc_out_if
// Result channel: valid/ready handshake with the filtered sample.
// ----------------------------------------------------------------------------
interface fcirc_out_if
  import fcirc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  filtered;
  logic                        clipped;

  modport source (
    output valid, filtered, clipped,
    input  ready
  );

  modport sink (
    input  valid, filtered, clipped,
    output ready
  );
endinterface

// File: rtl/core/fcirc_mac.sv
// ----------------------------------------------------------------------------
// fcirc_mac
// Shared multiply-accumulate unit: one registered 16x16 product per cycle,
// a wide accumulator, and round/saturate of the final sum.
// ----------------------------------------------------------------------------
module fcirc_mac
  import fcirc_pkg::*;
#(
  parameter int ACC_W = 42
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] w_i,
  input  logic signed [SAMPLE_W-1:0] h_i,
  output mac_stat_t                  stat_o,
  output logic signed [SAMPLE_W-1:0] filtered_o,
  output logic                       clipped_o
);

  localparam int SH_W = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= w_i * h_i;
    end
  end

  // Accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign stat_o.busy = prod_vld_q;

  // Round half up, arithmetic shift, clamp
  assign rnd     = acc_q + ACC_W'(ROUND_BIAS);
  assign shifted = SH_W'(rnd >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_MAX) begin
      filtered_o = SAMPLE_W'(SAT_MAX);
      clipped_o  = 1'b1;
    end else if (shifted < SAT_MIN) begin
      filtered_o = SAMPLE_W'(SAT_MIN);
      clipped_o  = 1'b1;
    end else begin
      filtered_o = SAMPLE_W'(shifted);
      clipped_o  = 1'b0;
    end
  end

endmodule

// File: rtl/core/fir_filter_circular.sv
// Sample item: the single shared multiply-accumulate steps through the taps
// in use, then the result is registered; the input is ready for the next item
// in the same cycle that the result turns valid, so samples do not overlap.
// Coefficient and clear items give no result.
// Reset: fill count and write position clear at once; a sweep then zeroes the
// weight memory, with the input held off until it finishes.
// ----------------------------------------------------------------------------
// fir_filter_circular
// Direct-form FIR filter over a circular sample history, runtime tap count,
// Q1.15 weights, one shared MAC under a small sequencer.
// ----------------------------------------------------------------------------
module fir_filter_circular
  import fcirc_pkg::*;
#(
  parameter int MAX_TAPS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TAPCNT_W-1:0] cfg_data_i,
  fcirc_in_if.sink            in_i,
  fcirc_out_if.source         out_o
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = PROD_W + AW;

  localparam logic [1:0] ST_WCLR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [TAPCNT_W-1:0]       tap_count_q;
  logic [AW-1:0]             wp_q;
  logic [CW-1:0]             fill_q;
  logic [AW-1:0]             j_q, k_q;
  logic                      issue_q;
  logic                      rd_vld_q;
  logic                      h_ok_q;
  logic [AW-1:0]             wclr_q;
  logic                      out_vld_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                      clipped_q;

  logic signed [SAMPLE_W-1:0] weights [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] w_rd_q, h_rd_q, h_op;

  logic [CW-1:0]             n_taps;
  logic [AW-1:0]             last_idx;
  logic                      in_xfer, filt_go, coef_go, clr_go, coef_ok;
  logic                      out_load;
  logic                      w_we;
  logic [AW-1:0]             w_waddr;
  logic signed [SAMPLE_W-1:0] w_wdata;
  mac_ctrl_t                 mac_ctrl;
  mac_stat_t                 mac_stat;
  logic signed [SAMPLE_W-1:0] mac_filtered;
  logic                      mac_clipped;

  // Taps in use: zero counts as one, clamp to the history depth
  always_comb begin
    if (tap_count_q == '0) begin
      n_taps = CW'(1);
    end else if (int'(tap_count_q) > MAX_TAPS) begin
      n_taps = CW'(MAX_TAPS);
    end else begin
      n_taps = CW'(tap_count_q);
    end
  end
  assign last_idx = AW'(n_taps - CW'(1));

  // Input decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign coef_ok    = int'(in_i.coef_index) < MAX_TAPS;

  always_comb begin
    filt_go = 1'b0;
    coef_go = 1'b0;
    clr_go  = 1'b0;
    unique case (cmd_e'(in_i.command))
      CMD_FILTER: filt_go = in_xfer;
      CMD_COEF:   coef_go = in_xfer & coef_ok;
      CMD_CLEAR:  clr_go  = in_xfer;
      default:    ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WCLR: if (wclr_q == AW'(MAX_TAPS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (filt_go) state_d = ST_MAC;
      ST_MAC: begin
        if (!issue_q && !rd_vld_q && !mac_stat.busy) state_d = ST_DONE;
      end
      ST_DONE: if (!out_vld_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WCLR;
      tap_count_q <= TAPCNT_W'(1);
      wp_q        <= '0;
      fill_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      h_ok_q      <= 1'b0;
      wclr_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // Weight clearing sweep after reset
      if (state_q == ST_WCLR) begin
        wclr_q <= wclr_q + AW'(1);
      end

      // History bookkeeping: config write and clear empty it
      if (cfg_we_i) begin
        tap_count_q <= cfg_data_i;
        wp_q        <= '0;
        fill_q      <= '0;
      end else if (clr_go) begin
        wp_q   <= '0;
        fill_q <= '0;
      end else if (filt_go) begin
        wp_q <= (wp_q == last_idx) ? '0 : wp_q + AW'(1);
        if (fill_q == CW'(wp_q)) begin
          fill_q <= fill_q + CW'(1);
        end
      end

      // Tap address issue: j up from 0, k down from the newest sample
      if (filt_go) begin
        issue_q <= 1'b1;
        j_q     <= '0;
        k_q     <= wp_q;
      end else if (issue_q) begin
        if (j_q == last_idx) begin
          issue_q <= 1'b0;
        end
        j_q <= j_q + AW'(1);
        k_q <= (k_q == '0) ? last_idx : k_q - AW'(1);
      end

      rd_vld_q <= issue_q;
      h_ok_q   <= CW'(k_q) < fill_q;

      // Output register
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Weight memory: clearing sweep or coefficient transfer
  assign w_we    = (state_q == ST_WCLR) || coef_go;
  assign w_waddr = (state_q == ST_WCLR) ? wclr_q : AW'(in_i.coef_index);
  assign w_wdata = (state_q == ST_WCLR) ? '0 : in_i.coef_value;

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      weights[w_waddr] <= w_wdata;
    end
    w_rd_q <= weights[j_q];
  end

  // History memory: newest sample lands at the write position
  always_ff @(posedge clk_i) begin
    if (filt_go) begin
      history[wp_q] <= in_i.sample_in;
    end
    h_rd_q <= history[k_q];
  end

  // Entries beyond the fill count were never written since the last clear
  assign h_op = h_ok_q ? h_rd_q : '0;

  assign mac_ctrl.start  = filt_go;
  assign mac_ctrl.mul_en = rd_vld_q;

  fcirc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .w_i        (w_rd_q),
    .h_i        (h_op),
    .stat_o     (mac_stat),
    .filtered_o (mac_filtered),
    .clipped_o  (mac_clipped)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= mac_filtered;
      clipped_q  <= mac_clipped;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = filtered_q;
  assign out_o.clipped  = clipped_q;

`ifndef ASSERT_OFF
  // No new item while taps are still being issued
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!issue_q && !rd_vld_q && !mac_stat.busy))
    else $error("input ready while the MAC pipeline is active");

  // History bookkeeping stays inside the active tap range
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= n_taps) && (CW'(wp_q) < n_taps))
    else $error("fill count or write position beyond tap count");

  // A result appears only out of the finishing state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the finishing state");

  // Finishing state is entered with the pipeline drained
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!issue_q && !rd_vld_q && !mac_stat.busy))
    else $error("finishing state with products in flight");
`endif

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular-history FIR filter. A clocked driver
// feeds sample, coefficient, clear and unused-command items from a queue and
// updates a bit-accurate filter predictor on every input transfer. A clocked
// monitor checks each output transfer against the oldest predicted sample.
// Both sides pause at random; the tap count is rewritten between phases.
// ----------------------------------------------------------------------------
module tb
  import fcirc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_TAPS   = 1024;
  localparam int          SETTLE     = 20;     // coef/clear items give no result to wait for
  localparam int          IDLE_LIMIT = 10000;  // covers reset sweep and 1024 taps
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COEF_IDX_W-1:0]      idx;
    logic signed [SAMPLE_W-1:0] coef;
  } fir_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } fir_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TAPCNT_W-1:0] cfg_data_i;

  fcirc_in_if  in_if ();
  fcirc_out_if out_if ();

  fir_filter_circular #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [SAMPLE_W-1:0] hist_mem   [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] weight_mem [MAX_TAPS];
  int unsigned                wr_pos;
  logic [TAPCNT_W-1:0]        tap_sel;

  fir_item_t   pend_q[$];    // items waiting for the driver
  fir_out_t    filt_q[$];    // predicted filter outputs, oldest first
  fir_item_t   tx_item;
  fir_out_t    got_want;
  int unsigned tx_gap;
  int unsigned rx_stall;
  int unsigned idle_cnt;
  int unsigned err_cnt;
  bit          gaps_on;
  bit          stalls_on;

  function automatic int unsigned taps_used();
    if (tap_sel == 0) return 1;
    if (tap_sel > MAX_TAPS) return MAX_TAPS;
    return 32'(tap_sel);
  endfunction

  function automatic void clear_history();
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_pos = 0;
  endfunction

  // Filter prediction for one accepted item
  function automatic void fir_predict(input fir_item_t it);
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    longint      acc;
    longint      res;
    fir_out_t    r;
    n = taps_used();
    case (it.cmd)
      CMD_COEF: begin
        if (it.idx < MAX_TAPS) weight_mem[it.idx] = it.coef;
      end
      CMD_CLEAR: begin
        clear_history();
      end
      CMD_FILTER: begin
        pos = (wr_pos < n) ? wr_pos : 0;
        hist_mem[pos] = it.sample;
        acc = 0;
        for (int unsigned j = 0; j < n; j++) begin
          k = (pos + n - j) % n;
          acc += longint'(weight_mem[j]) * longint'(hist_mem[k]);
        end
        wr_pos = (pos + 1) % n;
        // round half up, then clamp to the sample range
        res = (acc + ROUND_BIAS) >>> FRAC_BITS;
        r.clipped = 1'b0;
        if (res > SAT_MAX) begin
          res = SAT_MAX;
          r.clipped = 1'b1;
        end else if (res < SAT_MIN) begin
          res = SAT_MIN;
          r.clipped = 1'b1;
        end
        r.filtered = res[SAMPLE_W-1:0];
        filt_q.push_back(r);
      end
      default: ;  // unused command: no effect
    endcase
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
  endfunction

  function automatic void push_item(logic [1:0] c, int s, int i, int v);
    fir_item_t it;
    it.cmd    = c;
    it.sample = SAMPLE_W'(s);
    it.idx    = COEF_IDX_W'(i);
    it.coef   = SAMPLE_W'(v);
    pend_q.push_back(it);
  endfunction

  function automatic fir_item_t rand_item(int unsigned n);
    fir_item_t   it;
    int unsigned r;
    r         = $urandom_range(0, 99);
    it.sample = SAMPLE_W'($urandom);
    it.idx    = COEF_IDX_W'($urandom);
    it.coef   = SAMPLE_W'($urandom);
    if (r < 62) begin
      it.cmd = CMD_FILTER;
      if ($urandom_range(0, 4) == 0) it.sample = SAMPLE_W'($urandom_range(0, 511) - 256);
    end else if (r < 88) begin
      it.cmd = CMD_COEF;
      if ($urandom_range(0, 3) != 0) it.idx = COEF_IDX_W'($urandom_range(0, n - 1));
      if ($urandom_range(0, 1) == 0) it.coef = SAMPLE_W'($urandom_range(0, 4095) - 2048);
    end else if (r < 94) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // Wait until every item has gone and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || in_if.valid || filt_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Tap count write; the block restarts with an empty history
  task automatic write_tap_count(input logic [TAPCNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tap_sel = v;
    clear_history();
  endtask

  // Driver: offer queued items, hold each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.command    <= CMD_FILTER;
      in_if.sample_in  <= '0;
      in_if.coef_index <= '0;
      in_if.coef_value <= '0;
      tx_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) fir_predict(tx_item);
      if (in_if.valid && !in_if.ready) begin
        // keep offering the same item
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        tx_item = pend_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.command    <= tx_item.cmd;
        in_if.sample_in  <= tx_item.sample;
        in_if.coef_index <= tx_item.idx;
        in_if.coef_value <= tx_item.coef;
        tx_gap = (gaps_on && $urandom_range(0, 1) == 0) ? pick_len() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, check each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (filt_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_if.filtered));
        end else begin
          got_want = filt_q.pop_front();
          if (out_if.filtered !== got_want.filtered)
            report_mismatch($sformatf("filtered %0d, predicted %0d",
                                      out_if.filtered, got_want.filtered));
          if (out_if.clipped !== got_want.clipped)
            report_mismatch($sformatf("clipped %0b, predicted %0b",
                                      out_if.clipped, got_want.clipped));
        end
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 7) == 0) rx_stall = pick_len();
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      idle_cnt <= 0;
    end else if (idle_cnt == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned         n;
    int unsigned         cnt;
    logic [TAPCNT_W-1:0] phase_taps [13];

    phase_taps = '{11'd2, 11'd3, 11'd1, 11'd2047, 11'd5, 11'd8, 11'd13, 11'd0,
                   11'd1024, 11'd31, 11'd64, 11'd1025, 11'd6};

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    foreach (weight_mem[i]) weight_mem[i] = '0;
    tap_sel = 1;
    clear_history();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one tap at reset value, saturation and rounding
    push_item(CMD_COEF, 0, 0, -32768);
    push_item(CMD_FILTER, -32768, 0, 0);      // positive clip
    push_item(CMD_FILTER, 32767, 0, 0);
    push_item(CMD_FILTER, 0, 1023, 32767);
    push_item(CMD_COEF, 0, 0, 1);
    push_item(CMD_FILTER, 16384, 0, 0);       // exact half rounds up
    push_item(CMD_FILTER, -16384, 0, 0);
    push_item(CMD_FILTER, -16385, 0, 0);
    push_item(CMD_UNUSED, $urandom, $urandom, $urandom);
    push_item(CMD_COEF, 0, 1023, 32767);      // top tap index
    push_item(CMD_CLEAR, 0, 0, 0);
    push_item(CMD_FILTER, 1, 0, 0);
    wait_idle();

    // zero tap count behaves as one tap
    write_tap_count(11'd0);
    push_item(CMD_COEF, -1, 0, 32767);
    push_item(CMD_FILTER, 32767, 0, 0);
    wait_idle();

    // four taps at full weight: positive clip, then a mixed-sign history
    write_tap_count(11'd4);
    for (int i = 0; i < 4; i++) push_item(CMD_COEF, 0, i, 32767);
    for (int i = 0; i < 4; i++) push_item(CMD_FILTER, 32767, 0, 0);
    push_item(CMD_FILTER, -32768, 0, 0);
    push_item(CMD_FILTER, -32768, 0, 0);
    push_item(CMD_CLEAR, 0, 0, 0);
    push_item(CMD_FILTER, 100, 0, 0);

    // Random phases over several tap counts; a full drain halfway through each
    foreach (phase_taps[p]) begin
      wait_idle();
      write_tap_count(phase_taps[p]);
      n         = taps_used();
      cnt       = (n > 64) ? 12 : 40;
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < cnt; i++) begin
        if (i == cnt / 2) wait_idle();
        pend_q.push_back(rand_item(n));
      end
    end

    wait_idle();
    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
